FILE: sv/x86_64bit_shift_rotate_unit_macros.svh
// Assertion macros shared by the shift/rotate unit.
`ifndef X86_64BIT_SHIFT_ROTATE_UNIT_MACROS_SVH
`define X86_64BIT_SHIFT_ROTATE_UNIT_MACROS_SVH

// Checks that expr holds at every clock edge at which cond holds, outside reset.
`define SRU_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// Checks that cond never holds at a clock edge, outside reset.
`define SRU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

FILE: sv/srot_pkg.sv
// Types and constants shared by the shift/rotate unit.
package srot_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned FUNC_W   = 4;
    localparam int unsigned SHAMT_W  = 6;
    localparam int unsigned FINE_W   = 3;
    localparam int unsigned COARSE_W = SHAMT_W - FINE_W;
    localparam int unsigned FUNNEL_W = 2 * DATA_W;
    // Result plus one guard bit on each side for the carry.
    localparam int unsigned WIN_W    = DATA_W + 2;

    localparam logic [SHAMT_W-1:0] COUNT_MASK = 6'h3f;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SHL  = 4'd0,
        FUNC_SHR  = 4'd1,
        FUNC_SAR  = 4'd2,
        FUNC_ROL  = 4'd3,
        FUNC_ROR  = 4'd4,
        FUNC_RCL  = 4'd5,
        FUNC_RCR  = 4'd6,
        FUNC_SHLD = 4'd7,
        FUNC_SHRD = 4'd8
    } t_func;

    // Where the new carry comes from.
    typedef enum logic [1:0] {
        CF_LEFT,
        CF_RIGHT,
        CF_HOLD
    } t_cf_sel;

    // How the new overflow is formed.
    typedef enum logic [1:0] {
        OF_LEFT,
        OF_RIGHT,
        OF_CLEAR
    } t_of_sel;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DATA_W-1:0]  operand;
        logic [DATA_W-1:0]  fill_value;
        logic [COUNT_W-1:0] count_raw;
        logic               carry_in;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              updated;
        logic              arith_flags_updated;
        logic              carry_out;
        logic              overflow_out;
        logic              sign_out;
        logic              zero_out;
        logic              parity_out;
        logic              aux_out;
    } t_out_item;

    // Control that rides along with the data down the pipeline.
    typedef struct packed {
        logic    updated;
        logic    arith;
        t_cf_sel cf_sel;
        t_of_sel of_sel;
        logic    carry_in;
    } t_ctl;

    typedef struct packed {
        t_ctl                ctl;
        logic [FUNNEL_W-1:0] funnel;
        logic [SHAMT_W-1:0]  shamt;
    } t_dec;

    typedef struct packed {
        t_ctl                ctl;
        logic [FUNNEL_W-1:0] funnel;
        logic [COARSE_W-1:0] coarse;
    } t_fine;

    typedef struct packed {
        t_ctl             ctl;
        logic [WIN_W-1:0] win;
    } t_win;

endpackage

FILE: sv/x86_64bit_shift_rotate_unit.sv
// Top level of the 64-bit x86 shift and rotate execution unit.
//
// Each transaction on the input channel carries one SHL, SHR, SAR, ROL, ROR,
// RCL, RCR, SHLD or SHRD together with its operand, fill value, raw count and
// the current carry flag, and produces exactly one result transaction with the
// new value and the flags. The unit is a four-stage pipeline: decode, fine
// shift, coarse shift and flag formation, the last of which is the output
// register. It accepts one transaction every clock cycle while the output side
// does not stall. Every operation is mapped onto one 128-bit funnel shifter
// whose distance is split into a 0..7 bit step and a whole-byte step, one per
// stage. Each stage holds a valid bit and only advances when the stage after
// it is empty or moving, so a stall on the output side backs up through the
// stages without dropping or repeating a transaction. A masked count of zero,
// or an unknown operation code, returns the operand unchanged with updated low
// and the carry repeated from carry_in.
`include "x86_64bit_shift_rotate_unit_macros.svh"

module x86_64bit_shift_rotate_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  srot_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srot_pkg::t_out_item o_out_data
);

    logic           dec_valid;
    logic           dec_ready;
    srot_pkg::t_dec dec_data;
    logic           win_valid;
    logic           win_ready;
    srot_pkg::t_win win_data;
    logic           in_accept;

    assign in_accept = i_in_valid && o_in_ready;

    // Stage 1: count masking and funnel setup.
    srot_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_ready (o_in_ready),
        .o_valid (dec_valid),
        .o_data  (dec_data),
        .i_ready (dec_ready)
    );

    // Stages 2 and 3: the funnel shift itself.
    srot_shifter u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_data  (dec_data),
        .o_ready (dec_ready),
        .o_valid (win_valid),
        .o_data  (win_data),
        .i_ready (win_ready)
    );

    // Stage 4: flags and the output register.
    srot_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .i_data  (win_data),
        .o_ready (win_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

    // With the output register free to move, no stage can hold back the input.
    `SRU_ASSERT_IMPLY(a_ready_chain, i_clk, i_rst_n, (!o_out_valid || i_out_ready),
        o_in_ready, "input stalled while output side is free")

    // A transaction shows up on the output when nothing stalls after its acceptance.
    `SRU_ASSERT_IMPLY(a_latency, i_clk, i_rst_n,
        ($past(in_accept, 4) && $past(i_rst_n, 4) && $past(i_rst_n, 3) &&
         $past(i_rst_n, 2) && $past(i_rst_n, 1) && $past(i_out_ready, 3) &&
         $past(i_out_ready, 2) && $past(i_out_ready, 1)),
        o_out_valid, "result missing four cycles after acceptance")

    // Arithmetic flags are only written together with the destination, and AF stays clear.
    `SRU_ASSERT_NEVER(a_flag_coherent, i_clk, i_rst_n,
        (o_out_valid && (o_out_data.aux_out ||
         (o_out_data.arith_flags_updated && !o_out_data.updated))),
        "inconsistent flag update in result")

endmodule

FILE: sv/srot_decode.sv
// Decode stage: masks the count and builds the 128-bit funnel and shift amount.
module srot_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  srot_pkg::t_in_item i_data,
    output logic              o_ready,
    output logic              o_valid,
    output srot_pkg::t_dec    o_data,
    input  logic              i_ready
);

    logic                             r_valid;
    srot_pkg::t_dec                   r_data;
    srot_pkg::t_dec                   n_data;
    logic [srot_pkg::SHAMT_W-1:0]     count;
    logic [srot_pkg::SHAMT_W-1:0]     sh_left;
    logic [srot_pkg::SHAMT_W-1:0]     sh_right;
    logic [srot_pkg::DATA_W-1:0]      op;
    logic [srot_pkg::DATA_W-1:0]      hi;
    logic [srot_pkg::DATA_W-1:0]      lo;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // The window starts one bit below the result, so the stored amount is the
    // right-shift distance minus one: 63 - c for left moves, c - 1 for right.
    assign count    = i_data.count_raw[srot_pkg::SHAMT_W-1:0] & srot_pkg::COUNT_MASK;
    assign sh_left  = ~count;
    assign sh_right = count - srot_pkg::SHAMT_W'(1);
    assign op       = i_data.operand;

    always_comb begin
        // No-op: the funnel is laid out so a zero amount returns the operand.
        hi                  = {{(srot_pkg::DATA_W-1){1'b0}}, op[srot_pkg::DATA_W-1]};
        lo                  = {op[srot_pkg::DATA_W-2:0], 1'b0};
        n_data.shamt        = '0;
        n_data.ctl.updated  = 1'b0;
        n_data.ctl.arith    = 1'b0;
        n_data.ctl.cf_sel   = srot_pkg::CF_HOLD;
        n_data.ctl.of_sel   = srot_pkg::OF_CLEAR;
        n_data.ctl.carry_in = i_data.carry_in;
        if (count != '0) begin
            case (i_data.func)
                srot_pkg::FUNC_SHL: begin
                    hi = op;
                    lo = '0;
                    n_data.shamt      = sh_left;
                    n_data.ctl.cf_sel = srot_pkg::CF_LEFT;
                    n_data.ctl.of_sel = srot_pkg::OF_LEFT;
                end
                srot_pkg::FUNC_SHR: begin
                    hi = '0;
                    lo = op;
                    n_data.shamt      = sh_right;
                    n_data.ctl.cf_sel = srot_pkg::CF_RIGHT;
                    n_data.ctl.of_sel = srot_pkg::OF_RIGHT;
                end
                srot_pkg::FUNC_SAR: begin
                    hi = {srot_pkg::DATA_W{op[srot_pkg::DATA_W-1]}};
                    lo = op;
                    n_data.shamt      = sh_right;
                    n_data.ctl.cf_sel = srot_pkg::CF_RIGHT;
                    n_data.ctl.of_sel = srot_pkg::OF_CLEAR;
                end
                srot_pkg::FUNC_ROL: begin
                    hi = op;
                    lo = op;
                    n_data.shamt      = sh_left;
                    n_data.ctl.cf_sel = srot_pkg::CF_LEFT;
                    n_data.ctl.of_sel = srot_pkg::OF_LEFT;
                end
                srot_pkg::FUNC_ROR: begin
                    hi = op;
                    lo = op;
                    n_data.shamt      = sh_right;
                    n_data.ctl.cf_sel = srot_pkg::CF_RIGHT;
                    n_data.ctl.of_sel = srot_pkg::OF_RIGHT;
                end
                srot_pkg::FUNC_RCL: begin
                    hi = op;
                    lo = {i_data.carry_in, op[srot_pkg::DATA_W-1:1]};
                    n_data.shamt      = sh_left;
                    n_data.ctl.cf_sel = srot_pkg::CF_LEFT;
                    n_data.ctl.of_sel = srot_pkg::OF_LEFT;
                end
                srot_pkg::FUNC_RCR: begin
                    hi = {op[srot_pkg::DATA_W-2:0], i_data.carry_in};
                    lo = op;
                    n_data.shamt      = sh_right;
                    n_data.ctl.cf_sel = srot_pkg::CF_RIGHT;
                    n_data.ctl.of_sel = srot_pkg::OF_RIGHT;
                end
                srot_pkg::FUNC_SHLD: begin
                    hi = op;
                    lo = i_data.fill_value;
                    n_data.shamt      = sh_left;
                    n_data.ctl.cf_sel = srot_pkg::CF_LEFT;
                    n_data.ctl.of_sel = srot_pkg::OF_LEFT;
                end
                srot_pkg::FUNC_SHRD: begin
                    hi = i_data.fill_value;
                    lo = op;
                    n_data.shamt      = sh_right;
                    n_data.ctl.cf_sel = srot_pkg::CF_RIGHT;
                    n_data.ctl.of_sel = srot_pkg::OF_RIGHT;
                end
                default: begin
                    hi = {{(srot_pkg::DATA_W-1){1'b0}}, op[srot_pkg::DATA_W-1]};
                    lo = {op[srot_pkg::DATA_W-2:0], 1'b0};
                end
            endcase
            if (i_data.func inside {[srot_pkg::FUNC_SHL:srot_pkg::FUNC_SHRD]}) begin
                n_data.ctl.updated = 1'b1;
                n_data.ctl.arith   = i_data.func inside {srot_pkg::FUNC_SHL,
                                                         srot_pkg::FUNC_SHR,
                                                         srot_pkg::FUNC_SAR,
                                                         srot_pkg::FUNC_SHLD,
                                                         srot_pkg::FUNC_SHRD};
            end
        end
        n_data.funnel = {hi, lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: sv/srot_shifter.sv
// Two-stage funnel shifter: fine shift by 0..7, then coarse shift by bytes.
module srot_shifter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  srot_pkg::t_dec i_data,
    output logic           o_ready,
    output logic           o_valid,
    output srot_pkg::t_win o_data,
    input  logic           i_ready
);

    logic                          r_valid_a;
    logic                          r_valid_b;
    logic                          ready_b;
    srot_pkg::t_fine               r_fine;
    srot_pkg::t_fine               n_fine;
    srot_pkg::t_win                r_win;
    srot_pkg::t_win                n_win;
    logic [srot_pkg::FUNNEL_W-1:0] coarse_shifted;

    assign ready_b = !r_valid_b || i_ready;
    assign o_ready = !r_valid_a || ready_b;
    assign o_valid = r_valid_b;
    assign o_data  = r_win;

    always_comb begin
        n_fine.ctl    = i_data.ctl;
        n_fine.funnel = i_data.funnel >> i_data.shamt[srot_pkg::FINE_W-1:0];
        n_fine.coarse = i_data.shamt[srot_pkg::SHAMT_W-1:srot_pkg::FINE_W];
    end

    assign coarse_shifted = r_fine.funnel >> {r_fine.coarse, {srot_pkg::FINE_W{1'b0}}};

    always_comb begin
        n_win.ctl = r_fine.ctl;
        n_win.win = coarse_shifted[srot_pkg::WIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_fine <= n_fine;
        end
        if (ready_b && r_valid_a) begin
            r_win <= n_win;
        end
    end

endmodule

FILE: sv/srot_flags.sv
// Flag stage: picks carry and overflow, forms SF ZF PF AF, holds the output register.
module srot_flags (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  srot_pkg::t_win      i_data,
    output logic                o_ready,
    output logic                o_valid,
    output srot_pkg::t_out_item o_data,
    input  logic                i_ready
);

    logic                        r_valid;
    srot_pkg::t_out_item         r_data;
    srot_pkg::t_out_item         n_data;
    logic [srot_pkg::DATA_W-1:0] res;
    logic                        cf;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign res = i_data.win[srot_pkg::DATA_W:1];

    always_comb begin
        case (i_data.ctl.cf_sel)
            srot_pkg::CF_LEFT:  cf = i_data.win[srot_pkg::WIN_W-1];
            srot_pkg::CF_RIGHT: cf = i_data.win[0];
            default:            cf = i_data.ctl.carry_in;
        endcase
    end

    always_comb begin
        n_data.result              = res;
        n_data.updated             = i_data.ctl.updated;
        n_data.arith_flags_updated = i_data.ctl.arith;
        n_data.carry_out           = cf;
        case (i_data.ctl.of_sel)
            srot_pkg::OF_LEFT:  n_data.overflow_out = cf ^ res[srot_pkg::DATA_W-1];
            srot_pkg::OF_RIGHT: n_data.overflow_out = res[srot_pkg::DATA_W-1] ^
                                                      res[srot_pkg::DATA_W-2];
            default:            n_data.overflow_out = 1'b0;
        endcase
        n_data.sign_out   = i_data.ctl.arith & res[srot_pkg::DATA_W-1];
        n_data.zero_out   = i_data.ctl.arith & (res == '0);
        n_data.parity_out = i_data.ctl.arith & ~(^res[7:0]);
        n_data.aux_out    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: tb/sv/tb_x86_64bit_shift_rotate_unit.sv
// Self-checking testbench for the 64-bit x86 shift and rotate unit.
`timescale 1ns / 1ps

module tb_x86_64bit_shift_rotate_unit;

    import srot_pkg::*;

    // Operation codes that the unit does not implement. They must come back
    // unchanged, just like a zero masked count.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned STALL_LEN    = 100;   // long output hold-off, in cycles
    localparam int unsigned DRAIN_CYCLES = 20;    // pipeline is four stages deep
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned MAX_REPORTS  = 200;

    localparam logic [DATA_W-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] PATTERN  = 64'h0123_4567_89ab_cdef;

    // An accepted input transaction together with the result it must produce.
    typedef struct packed {
        t_in_item  stim;
        t_out_item want;
    } t_pending;

    // Every input is given a known value from time zero.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    t_in_item  stim_q[$];        // transactions still to be offered
    t_pending  predicted_q[$];   // accepted transactions awaiting their result
    t_pending  sent_entry;       // used by the driver only
    t_pending  got_entry;        // used by the monitor only

    int unsigned n_errors    = 0;
    int unsigned n_sent      = 0;
    int unsigned n_got       = 0;
    int unsigned n_zero_cnt  = 0;
    int unsigned n_holds     = 0;
    int unsigned n_in_stalls = 0;
    int unsigned op_seen[16];
    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned hold_left;
    int unsigned cycle_count = 0;

    x86_64bit_shift_rotate_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. Works out the complete result transaction for one input.
    // RCL and RCR are handled as a rotate of the 65-bit ring formed by the
    // carry on top of the operand, which is exactly what the instructions
    // do once the count has been masked to six bits.
    // ------------------------------------------------------------------
    function automatic t_out_item shift_rotate_expect(t_in_item it);
        t_out_item         res;
        logic [DATA_W-1:0] op;
        logic [DATA_W-1:0] r;
        logic [DATA_W:0]   ring;
        int unsigned       amt;
        logic              cf;
        logic              of;
        logic              arith;
        res   = '0;
        op    = it.operand;
        amt   = 32'(it.count_raw[SHAMT_W-1:0] & COUNT_MASK);
        ring  = {it.carry_in, op};
        r     = op;
        cf    = 1'b0;
        of    = 1'b0;
        arith = 1'b0;

        // Nothing is written: the value passes through and CF keeps its value.
        if (amt == 0 || it.func > FUNC_SHRD) begin
            res.result    = op;
            res.carry_out = it.carry_in;
            return res;
        end

        // From here 1 <= amt <= 63. Left-type operations take OF from the new
        // carry and the new top bit, right-type ones from the top two bits; SAR clears it.
        case (it.func)
            FUNC_SHL: begin
                r     = op << amt;
                cf    = op[64 - amt];
                of    = cf ^ r[63];
                arith = 1'b1;
            end
            FUNC_SHR: begin
                r     = op >> amt;
                cf    = op[amt - 1];
                of    = r[63] ^ r[62];
                arith = 1'b1;
            end
            FUNC_SAR: begin
                r     = $signed(op) >>> amt;
                cf    = op[amt - 1];
                of    = 1'b0;
                arith = 1'b1;
            end
            FUNC_ROL: begin
                r  = (op << amt) | (op >> (64 - amt));
                cf = r[0];
                of = cf ^ r[63];
            end
            FUNC_ROR: begin
                r  = (op >> amt) | (op << (64 - amt));
                cf = r[63];
                of = r[63] ^ r[62];
            end
            FUNC_RCL: begin
                ring = (ring << amt) | (ring >> (65 - amt));
                r    = ring[DATA_W-1:0];
                cf   = ring[DATA_W];
                of   = cf ^ r[63];
            end
            FUNC_RCR: begin
                ring = (ring >> amt) | (ring << (65 - amt));
                r    = ring[DATA_W-1:0];
                cf   = ring[DATA_W];
                of   = r[63] ^ r[62];
            end
            FUNC_SHLD: begin
                r     = (op << amt) | (it.fill_value >> (64 - amt));
                cf    = op[64 - amt];
                of    = cf ^ r[63];
                arith = 1'b1;
            end
            FUNC_SHRD: begin
                r     = (it.fill_value << (64 - amt)) | (op >> amt);
                cf    = op[amt - 1];
                of    = r[63] ^ r[62];
                arith = 1'b1;
            end
            default: begin
                r = op;
            end
        endcase

        res.result              = r;
        res.updated             = 1'b1;
        res.arith_flags_updated = arith;
        res.carry_out           = cf;
        res.overflow_out        = of;
        // Rotates leave SF, ZF, PF and AF alone, so those come back as zero.
        if (arith) begin
            res.sign_out   = r[63];
            res.zero_out   = (r == '0);
            res.parity_out = ~^r[7:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking helpers.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %h, actual %h",
                         $time, name, want, got);
        end
    endtask

    task automatic check_bit(string name, logic want, logic got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected %b, actual %b",
                         $time, name, want, got);
        end
    endtask

    task automatic compare_result(t_pending p, t_out_item got);
        int unsigned errs_before;
        errs_before = n_errors;
        check_field("result",            p.want.result,              got.result);
        check_bit("updated",             p.want.updated,             got.updated);
        check_bit("arith_flags_updated", p.want.arith_flags_updated, got.arith_flags_updated);
        check_bit("carry_out",           p.want.carry_out,           got.carry_out);
        check_bit("overflow_out",        p.want.overflow_out,        got.overflow_out);
        check_bit("sign_out",            p.want.sign_out,            got.sign_out);
        check_bit("zero_out",            p.want.zero_out,            got.zero_out);
        check_bit("parity_out",          p.want.parity_out,          got.parity_out);
        check_bit("aux_out",             p.want.aux_out,             got.aux_out);
        if (n_errors != errs_before && n_errors <= MAX_REPORTS)
            $display("    for func %0d operand %h fill %h count %h carry %b",
                     p.stim.func, p.stim.operand, p.stim.fill_value,
                     p.stim.count_raw, p.stim.carry_in);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_in_item make_op(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] op,
                                         logic [DATA_W-1:0] fill, logic [COUNT_W-1:0] cnt,
                                         logic cin);
        t_in_item it;
        it.func       = func;
        it.operand    = op;
        it.fill_value = fill;
        it.count_raw  = cnt;
        it.carry_in   = cin;
        return it;
    endfunction

    // Random words half of the time, the rest corner values that make the
    // carry, overflow and zero flags interesting.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return TOP_BIT;
            3:       return 64'h1;
            4:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Raw counts: the masked range dominates, but zero after masking, the
    // extremes and garbage in the two upper bits all show up regularly.
    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return {2'($urandom_range(0, 3)), 6'd0};
            1:       return 8'($urandom_range(0, 255));
            2:       return {2'($urandom_range(0, 3)), 6'd1};
            3:       return {2'($urandom_range(0, 3)), 6'd63};
            default: return 8'($urandom_range(1, 63));
        endcase
    endfunction

    // Wait drawn per transaction on either side; calm stretches run flat out.
    function automatic int unsigned idle_draw(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------------------
    // Driver. Offers the queued transactions, holding valid and the payload
    // steady until the unit takes them, and records the expected result at
    // the edge where each transaction is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            send_idle = 0;
        end else begin
            if (in_valid && !in_ready)
                n_in_stalls++;
            if (in_valid && in_ready) begin
                sent_entry.stim = in_data;
                sent_entry.want = shift_rotate_expect(in_data);
                predicted_q.push_back(sent_entry);
                op_seen[in_data.func]++;
                if (in_data.count_raw[SHAMT_W-1:0] == '0)
                    n_zero_cnt++;
                n_sent++;
                send_idle = idle_draw(((n_sent / 64) % 3) == 2);
            end
            // The channel is free for a new transaction unless one is still
            // waiting to be taken.
            if (!in_valid || in_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    in_data  <= stim_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Takes result transactions, compares each against the oldest
    // prediction, and throttles ready. Twice in the run it holds ready low
    // for a long stretch so that the pipeline fills and pushes back on the
    // input side while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_idle = 0;
            hold_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (predicted_q.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: result with nothing expected: expected none, actual %h",
                             $time, out_data);
                end else begin
                    got_entry = predicted_q.pop_front();
                    compare_result(got_entry, out_data);
                end
                n_got++;
                recv_idle = idle_draw(((n_got / 48) % 3) == 1);
                if (n_got == 150 || n_got == 450) begin
                    hold_left = STALL_LEN;
                    n_holds++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, reset, then wait for everything to drain.
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 16; i++)
            op_seen[i] = 0;

        // Directed part: both count extremes for every operation, carry-in
        // entering the ring at a count of one, a zero result, zero masked
        // counts (including one with the upper bits set) and unused codes.
        stim_q.push_back(make_op(FUNC_SHL,  TOP_BIT | 64'h1, '0, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_SHL,  ALL_ONES, '0, 8'd63, 1'b1));
        stim_q.push_back(make_op(FUNC_SHL,  64'h1, '0, 8'hff, 1'b0));
        stim_q.push_back(make_op(FUNC_SHR,  TOP_BIT, '0, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_SHR,  ALL_ONES, '0, 8'd63, 1'b0));
        stim_q.push_back(make_op(FUNC_SAR,  TOP_BIT | 64'h1, '0, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_SAR,  ALL_ONES, '0, 8'd63, 1'b1));
        stim_q.push_back(make_op(FUNC_SAR,  ~TOP_BIT, '0, 8'd63, 1'b0));
        stim_q.push_back(make_op(FUNC_ROL,  TOP_BIT, '0, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_ROL,  PATTERN, '0, 8'd63, 1'b1));
        stim_q.push_back(make_op(FUNC_ROR,  64'h1, '0, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_ROR,  PATTERN, '0, 8'd63, 1'b0));
        stim_q.push_back(make_op(FUNC_RCL,  '0, '0, 8'd1, 1'b1));
        stim_q.push_back(make_op(FUNC_RCL,  TOP_BIT, '0, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_RCL,  ALL_ONES, '0, 8'd63, 1'b0));
        stim_q.push_back(make_op(FUNC_RCR,  '0, '0, 8'd1, 1'b1));
        stim_q.push_back(make_op(FUNC_RCR,  64'h1, '0, 8'd63, 1'b1));
        stim_q.push_back(make_op(FUNC_SHLD, '0, ALL_ONES, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_SHLD, ALL_ONES, PATTERN, 8'd63, 1'b0));
        stim_q.push_back(make_op(FUNC_SHRD, '0, ALL_ONES, 8'd1, 1'b0));
        stim_q.push_back(make_op(FUNC_SHRD, TOP_BIT, ~PATTERN, 8'd63, 1'b1));
        stim_q.push_back(make_op(FUNC_SHL,  PATTERN, '0, 8'd0, 1'b1));
        stim_q.push_back(make_op(FUNC_RCL,  ALL_ONES, ALL_ONES, 8'd64, 1'b0));
        stim_q.push_back(make_op(FUNC_UNUSED_LO, ALL_ONES, '0, 8'd5, 1'b1));
        stim_q.push_back(make_op(FUNC_UNUSED_HI, PATTERN, ALL_ONES, 8'hc1, 1'b0));

        // Random part: mostly legal operations, a small share of unused codes.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            stim_q.push_back(make_op(
                ($urandom_range(0, 15) == 0)
                    ? FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI))
                    : FUNC_W'($urandom_range(FUNC_SHL, FUNC_SHRD)),
                rand_word(), rand_word(), rand_count(), 1'($urandom_range(0, 1))));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // All stimulus taken, then all results back, then a quiet tail to
        // catch anything spurious coming out of the pipeline.
        while (stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (predicted_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d transactions: SHL %0d, SHR %0d, SAR %0d, ROL %0d, ROR %0d, ",
                 n_got, op_seen[FUNC_SHL], op_seen[FUNC_SHR], op_seen[FUNC_SAR],
                 op_seen[FUNC_ROL], op_seen[FUNC_ROR]);
        $display("RCL %0d, RCR %0d, SHLD %0d, SHRD %0d; %0d zero counts, %0d long holds, %s",
                 op_seen[FUNC_RCL], op_seen[FUNC_RCR], op_seen[FUNC_SHLD],
                 op_seen[FUNC_SHRD], n_zero_cnt, n_holds,
                 $sformatf("%0d input stall cycles.", n_in_stalls));
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/srot_pkg.sv
sv/srot_decode.sv
sv/srot_shifter.sv
sv/srot_flags.sv
sv/x86_64bit_shift_rotate_unit.sv
tb/sv/tb_x86_64bit_shift_rotate_unit.sv
